FILE: rtl/rptw_pkg.sv
package rptw_pkg;

    localparam int NUM_TABLES = 64;
    localparam int INDEX_BITS = 9;
    localparam int MAX_LEVELS = 5;
    localparam int PAGE_SHIFT = 12;

    localparam int TBL_W     = $clog2(NUM_TABLES);
    localparam int FREE_W    = $clog2(NUM_TABLES + 1);
    localparam int ENTRIES   = 1 << INDEX_BITS;
    localparam int LINK_DEPTH = NUM_TABLES * ENTRIES;
    localparam int ADDR_W    = TBL_W + INDEX_BITS;
    localparam int PFN_W     = MAX_LEVELS * INDEX_BITS;
    localparam int DVMA_W    = 57;
    localparam int NPAGES_W  = 32;
    localparam int LVL_W     = 3;
    localparam int TNUM_W    = 6;
    localparam int CNT_W     = 10;
    localparam int PTE_W     = 64;
    localparam int BASE_W    = 52;
    localparam int MASK_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 52;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVELS = 3'd0,
        CFG_BASE   = 3'd1,
        CFG_READ   = 3'd2,
        CFG_WRITE  = 3'd3,
        CFG_TYPE2  = 3'd4,
        CFG_TYPE3  = 3'd5,
        CFG_TYPE4  = 3'd6,
        CFG_TYPE5  = 3'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FINAL,
        ST_EMIT
    } t_state;

    typedef enum logic {
        FUNC_LOOKUP = 1'b0,
        FUNC_MAP    = 1'b1
    } t_func;

    typedef struct packed {
        logic              is_final;
        logic              last;
        logic [LVL_W-1:0]  level;
        logic [TNUM_W-1:0] table_number;
        logic [INDEX_BITS-1:0] entry_index;
        logic [PTE_W-1:0]  pte_value;
        logic              found;
        logic [CNT_W-1:0]  count;
        logic              pool_exhausted;
    } t_result;

endpackage

FILE: rtl/rptw_ram.sv
module rptw_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/radix_page_table_walk_alloc.sv
// Channel | valid       | ready       | payload
// input   | i_in_valid  | o_in_ready  | i_func, i_dvma, i_npages
// result  | o_out_valid | i_out_ready | o_is_final .. o_pool_exhausted
// config  | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each walked level goes through the single link store read port: ST_READ
// presents the address and ST_CHECK sees the registered data. A level that
// allocates a table adds an ST_EMIT result slot; the final result passes
// through ST_FINAL and ST_EMIT. After reset a clearing pass zeroes all 32768
// link store entries, with o_in_ready low. A result waits in the output
// register; a stalled result side holds the walk at its next result.
module radix_page_table_walk_alloc (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_func,
    input  logic [rptw_pkg::DVMA_W-1:0]            i_dvma,
    input  logic [rptw_pkg::NPAGES_W-1:0]          i_npages,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_is_final,
    output logic                                   o_last,
    output logic [rptw_pkg::LVL_W-1:0]             o_level,
    output logic [rptw_pkg::TNUM_W-1:0]            o_table_number,
    output logic [rptw_pkg::INDEX_BITS-1:0]        o_entry_index,
    output logic [rptw_pkg::PTE_W-1:0]             o_pte_value,
    output logic                                   o_found,
    output logic [rptw_pkg::CNT_W-1:0]             o_count,
    output logic                                   o_pool_exhausted,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rptw_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rptw_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int IB = rptw_pkg::INDEX_BITS;

    rptw_pkg::t_state r_state, n_state;

    logic [rptw_pkg::LVL_W-1:0]   r_cfg_levels;
    logic [rptw_pkg::BASE_W-1:0]  r_cfg_base;
    logic [rptw_pkg::MASK_W-1:0]  r_cfg_read, r_cfg_write;
    logic [rptw_pkg::MASK_W-1:0]  r_cfg_type2, r_cfg_type3, r_cfg_type4, r_cfg_type5;

    logic [rptw_pkg::ADDR_W-1:0]  r_clr;
    logic [rptw_pkg::FREE_W-1:0]  r_next_free;
    logic                         r_func;
    logic [rptw_pkg::PFN_W-1:0]   r_pfn;
    logic [rptw_pkg::NPAGES_W-1:0] r_npages;
    logic [rptw_pkg::LVL_W-1:0]   r_lv;
    logic [rptw_pkg::TBL_W-1:0]   r_table;
    rptw_pkg::t_result            r_pend;
    rptw_pkg::t_result            r_out;
    logic                         r_out_valid;

    logic                         w_in_xfer;
    logic                         w_slot_free;
    logic [rptw_pkg::LVL_W-1:0]   w_start_lv;
    logic [IB-1:0]                w_idx;
    logic [rptw_pkg::ADDR_W-1:0]  w_slot;
    logic [rptw_pkg::TBL_W-1:0]   w_child;
    logic [rptw_pkg::TBL_W-1:0]   w_new_tbl;
    logic                         w_pool_empty;
    logic [rptw_pkg::MASK_W-1:0]  w_type;
    logic [rptw_pkg::BASE_W-1:0]  w_page;
    logic [rptw_pkg::PTE_W-1:0]   w_pte;
    logic [rptw_pkg::CNT_W-1:0]   w_avail;
    logic [rptw_pkg::CNT_W-1:0]   w_cnt;

    logic                         w_mem_we;
    logic [rptw_pkg::ADDR_W-1:0]  w_mem_waddr;
    logic [rptw_pkg::TBL_W-1:0]   w_mem_wdata;
    logic                         w_mem_re;

    rptw_ram #(
        .WIDTH (rptw_pkg::TBL_W),
        .DEPTH (rptw_pkg::LINK_DEPTH)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_slot),
        .o_rdata (w_child)
    );

    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_cfg_levels < rptw_pkg::LVL_W'(2)) begin
            w_start_lv = rptw_pkg::LVL_W'(2);
        end else if (r_cfg_levels > rptw_pkg::LVL_W'(rptw_pkg::MAX_LEVELS)) begin
            w_start_lv = rptw_pkg::LVL_W'(rptw_pkg::MAX_LEVELS);
        end else begin
            w_start_lv = r_cfg_levels;
        end
    end

    always_comb begin
        case (r_lv)
            3'd2:    w_idx = r_pfn[IB*1 +: IB];
            3'd3:    w_idx = r_pfn[IB*2 +: IB];
            3'd4:    w_idx = r_pfn[IB*3 +: IB];
            3'd5:    w_idx = r_pfn[IB*4 +: IB];
            default: w_idx = r_pfn[IB*0 +: IB];
        endcase
    end

    always_comb begin
        case (r_lv)
            3'd2:    w_type = r_cfg_type2;
            3'd3:    w_type = r_cfg_type3;
            3'd4:    w_type = r_cfg_type4;
            3'd5:    w_type = r_cfg_type5;
            default: w_type = '0;
        endcase
    end

    assign w_slot       = {r_table, w_idx};
    assign w_new_tbl    = r_next_free[rptw_pkg::TBL_W-1:0];
    assign w_pool_empty = r_next_free >= rptw_pkg::FREE_W'(rptw_pkg::NUM_TABLES);
    assign w_page       = r_cfg_base + rptw_pkg::BASE_W'(w_new_tbl);
    assign w_pte        = {w_page, {rptw_pkg::PAGE_SHIFT{1'b0}}}
                        | rptw_pkg::PTE_W'(r_cfg_read)
                        | rptw_pkg::PTE_W'(r_cfg_write)
                        | rptw_pkg::PTE_W'(w_type);
    assign w_avail      = rptw_pkg::CNT_W'(rptw_pkg::ENTRIES) - rptw_pkg::CNT_W'(r_pfn[IB-1:0]);
    assign w_cnt        = (r_npages < rptw_pkg::NPAGES_W'(w_avail)) ?
                          r_npages[rptw_pkg::CNT_W-1:0] : w_avail;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rptw_pkg::ST_CLEAR: begin
                if (r_clr == {rptw_pkg::ADDR_W{1'b1}}) begin
                    n_state = rptw_pkg::ST_IDLE;
                end
            end
            rptw_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = rptw_pkg::ST_READ;
                end
            end
            rptw_pkg::ST_READ: begin
                n_state = rptw_pkg::ST_CHECK;
            end
            rptw_pkg::ST_CHECK: begin
                if (w_child != '0) begin
                    n_state = (r_lv == rptw_pkg::LVL_W'(2)) ? rptw_pkg::ST_FINAL
                                                            : rptw_pkg::ST_READ;
                end else begin
                    n_state = rptw_pkg::ST_EMIT;
                end
            end
            rptw_pkg::ST_FINAL: begin
                n_state = rptw_pkg::ST_EMIT;
            end
            rptw_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    if (r_pend.is_final) begin
                        n_state = rptw_pkg::ST_IDLE;
                    end else if (r_lv == rptw_pkg::LVL_W'(1)) begin
                        n_state = rptw_pkg::ST_FINAL;
                    end else begin
                        n_state = rptw_pkg::ST_READ;
                    end
                end
            end
            default: n_state = rptw_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = w_slot;
        w_mem_wdata = w_new_tbl;
        w_mem_re    = 1'b0;
        case (r_state)
            rptw_pkg::ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr;
                w_mem_wdata = '0;
            end
            rptw_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            rptw_pkg::ST_READ: begin
                w_mem_re = 1'b1;
            end
            rptw_pkg::ST_CHECK: begin
                w_mem_we = (w_child == '0) && (r_func == rptw_pkg::FUNC_MAP) && !w_pool_empty;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rptw_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_next_free  <= rptw_pkg::FREE_W'(1);
            r_out_valid  <= 1'b0;
            r_cfg_levels <= rptw_pkg::LVL_W'(4);
            r_cfg_base   <= '0;
            r_cfg_read   <= rptw_pkg::MASK_W'(1);
            r_cfg_write  <= rptw_pkg::MASK_W'(2);
            r_cfg_type2  <= '0;
            r_cfg_type3  <= '0;
            r_cfg_type4  <= '0;
            r_cfg_type5  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == rptw_pkg::ST_CLEAR) begin
                r_clr <= r_clr + rptw_pkg::ADDR_W'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rptw_pkg::CFG_LEVELS: r_cfg_levels <= i_cfg_data[rptw_pkg::LVL_W-1:0];
                    rptw_pkg::CFG_BASE:   r_cfg_base   <= i_cfg_data[rptw_pkg::BASE_W-1:0];
                    rptw_pkg::CFG_READ:   r_cfg_read   <= i_cfg_data[rptw_pkg::MASK_W-1:0];
                    rptw_pkg::CFG_WRITE:  r_cfg_write  <= i_cfg_data[rptw_pkg::MASK_W-1:0];
                    rptw_pkg::CFG_TYPE2:  r_cfg_type2  <= i_cfg_data[rptw_pkg::MASK_W-1:0];
                    rptw_pkg::CFG_TYPE3:  r_cfg_type3  <= i_cfg_data[rptw_pkg::MASK_W-1:0];
                    rptw_pkg::CFG_TYPE4:  r_cfg_type4  <= i_cfg_data[rptw_pkg::MASK_W-1:0];
                    rptw_pkg::CFG_TYPE5:  r_cfg_type5  <= i_cfg_data[rptw_pkg::MASK_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == rptw_pkg::ST_CHECK && w_mem_we) begin
                r_next_free <= r_next_free + rptw_pkg::FREE_W'(1);
            end
            if (r_state == rptw_pkg::ST_EMIT && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rptw_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    r_func   <= i_func;
                    r_pfn    <= i_dvma[rptw_pkg::DVMA_W-1 -: rptw_pkg::PFN_W];
                    r_npages <= i_npages;
                    r_lv     <= w_start_lv;
                    r_table  <= '0;
                end
            end
            rptw_pkg::ST_CHECK: begin
                r_pend.is_final       <= 1'b1;
                r_pend.last           <= 1'b1;
                r_pend.level          <= r_lv;
                r_pend.table_number   <= rptw_pkg::TNUM_W'(r_table);
                r_pend.entry_index    <= w_idx;
                r_pend.pte_value      <= '0;
                r_pend.found          <= 1'b0;
                r_pend.count          <= '0;
                r_pend.pool_exhausted <= 1'b0;
                if (w_child != '0) begin
                    r_table <= w_child;
                    r_lv    <= r_lv - rptw_pkg::LVL_W'(1);
                end else if (r_func == rptw_pkg::FUNC_MAP) begin
                    if (w_pool_empty) begin
                        r_pend.pool_exhausted <= 1'b1;
                    end else begin
                        r_pend.is_final  <= 1'b0;
                        r_pend.last      <= 1'b0;
                        r_pend.pte_value <= w_pte;
                        r_table          <= w_new_tbl;
                        r_lv             <= r_lv - rptw_pkg::LVL_W'(1);
                    end
                end
            end
            rptw_pkg::ST_FINAL: begin
                r_pend.is_final       <= 1'b1;
                r_pend.last           <= 1'b1;
                r_pend.level          <= rptw_pkg::LVL_W'(1);
                r_pend.table_number   <= rptw_pkg::TNUM_W'(r_table);
                r_pend.entry_index    <= r_pfn[IB-1:0];
                r_pend.pte_value      <= '0;
                r_pend.found          <= 1'b1;
                r_pend.count          <= w_cnt;
                r_pend.pool_exhausted <= 1'b0;
            end
            rptw_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    r_out <= r_pend;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_is_final       = r_out.is_final;
    assign o_last           = r_out.last;
    assign o_level          = r_out.level;
    assign o_table_number   = r_out.table_number;
    assign o_entry_index    = r_out.entry_index;
    assign o_pte_value      = r_out.pte_value;
    assign o_found          = r_out.found;
    assign o_count          = r_out.count;
    assign o_pool_exhausted = r_out.pool_exhausted;

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rptw_pkg::ST_CLEAR) |-> !o_out_valid)
        else $error("result presented during link store clear");

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= rptw_pkg::FREE_W'(rptw_pkg::NUM_TABLES))
        else $error("table allocator ran past the pool");

    a_final_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_final) |-> (o_last && o_pte_value == '0))
        else $error("final result without last or with entry value");

    a_miss_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_count == '0))
        else $error("count reported without reaching the leaf");

    a_link_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_we && r_state != rptw_pkg::ST_CLEAR) |-> (w_mem_wdata != '0))
        else $error("walk wrote an empty link");

endmodule
